[rtl/core/matrix_multiply_transposable_core_assert.svh]
// Assertion macros shared by the matrix multiply core
`ifndef MATRIX_MULTIPLY_TRANSPOSABLE_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MMT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define MMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/mmt_pkg.sv]
// Package: types, codes and default sizes of the matrix multiply core
`timescale 1ns / 1ps
package mmt_pkg;

   // default sizes
   localparam int MAX_DIM_DEF    = 8;
   localparam int MAX_ELEMS_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed port widths
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int OPCODE_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_A,
      OP_WRITE_B,
      OP_COMPUTE
   } opcode_type;

   typedef enum logic [1:0] {
      LAYOUT_PLAIN,
      LAYOUT_A_T,
      LAYOUT_B_T
   } layout_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_LAYOUT,
      CFG_INNER,
      CFG_ROWS,
      CFG_COLS
   } cfg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } seq_state_type;

   // one term of the multiply-accumulate walk as it moves down the pipe
   typedef struct packed {
      logic               valid;
      logic               first;  // first term of an element
      logic               fin;    // final term of an element
      logic               last;   // element is the final one of the product
      logic [INDEX_W-1:0] idx;    // column-major result index
   } term_ctrl_type;

endpackage

[rtl/core/matrix_multiply_transposable_core.sv]
// Top level of the transposable fixed-point matrix multiply core
//
//  channel  | ports                                  | flow control
//  ---------+----------------------------------------+---------------------------
//  command  | start, busy, req_*                     | taken when start && !busy
//  result   | rsp_valid, rsp_*                       | no stall
//  config   | csr_we, csr_index, csr_wdata           | written when csr_we
//
// An element write leaves busy low, and writes may follow back to back.
// A compute issues its terms through one shared multiplier, one term a cycle,
// and results trail the last term by four pipeline stages (read, multiply,
// accumulate, output). Reset clears both stores at once through per-entry valid bits.
// Results cannot be stalled; each word is shown for exactly one cycle.
`timescale 1ns / 1ps
module matrix_multiply_transposable_core
   import mmt_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic [INDEX_W-1:0]        req_elem_index,
   input  logic signed [VALUE_W-1:0] req_elem_value,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_prod_value,
   output logic [INDEX_W-1:0]        rsp_prod_index,
   output logic                      rsp_overflowed,
   output logic                      rsp_last_elem,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DIMW = $clog2(MAX_DIM + 1);
   localparam int AW   = $clog2(MAX_ELEMS);
   localparam int SPAN = (MAX_DIM * MAX_DIM > MAX_ELEMS) ? MAX_DIM * MAX_DIM : MAX_ELEMS;
   localparam int IW   = $clog2(SPAN);

   logic [1:0]            layout_ff;
   logic [CSR_DATA_W-1:0] inner_ff, rows_ff, cols_ff;
   logic [DIMW-1:0]       dim_k, dim_r, dim_c;
   logic                  take, cmd_go, wr_en, wr_to_b, idx_ok;
   logic                  seq_busy, done;
   term_ctrl_type         term_s0, term_s1;
   logic [IW-1:0]         addr_a, addr_b;
   logic signed [DATA_WIDTH-1:0] opa, opb;

   // dimension clamp: zero acts as one, oversize as the maximum
   function automatic logic [DIMW-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIMW-1:0] r;
      if (v == '0) begin
         r = DIMW'(1);
      end else if (v > CSR_DATA_W'(MAX_DIM)) begin
         r = DIMW'(MAX_DIM);
      end else begin
         r = v[DIMW-1:0];
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_PLAIN;
         inner_ff  <= CSR_DATA_W'(8);
         rows_ff   <= CSR_DATA_W'(8);
         cols_ff   <= CSR_DATA_W'(8);
      end else if (csr_we) begin
         case (csr_index)
            CFG_LAYOUT: layout_ff <= csr_wdata[1:0];
            CFG_INNER:  inner_ff  <= csr_wdata;
            CFG_ROWS:   rows_ff   <= csr_wdata;
            CFG_COLS:   cols_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign dim_k = clamp_dim(inner_ff);
   assign dim_r = clamp_dim(rows_ff);
   assign dim_c = clamp_dim(cols_ff);

   // command decode
   assign take    = start && !seq_busy;
   assign cmd_go  = take && (req_opcode == OP_COMPUTE);
   assign idx_ok  = ({1'b0, req_elem_index} < (INDEX_W+1)'(MAX_ELEMS));
   assign wr_to_b = (req_opcode == OP_WRITE_B);
   assign wr_en   = take && idx_ok && (req_opcode == OP_WRITE_A || req_opcode == OP_WRITE_B);
   assign done    = rsp_valid && rsp_last_elem;
   assign busy    = seq_busy;

   mmt_seq #(.MAX_DIM(MAX_DIM), .MAX_ELEMS(MAX_ELEMS)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cmd_go (cmd_go),
      .done_i (done),
      .layout (layout_ff),
      .dim_k  (dim_k),
      .dim_r  (dim_r),
      .dim_c  (dim_c),
      .busy   (seq_busy),
      .term   (term_s0),
      .addr_a (addr_a),
      .addr_b (addr_b)
   );

   mmt_store #(.DATA_WIDTH(DATA_WIDTH), .MAX_DIM(MAX_DIM), .MAX_ELEMS(MAX_ELEMS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_to_b  (wr_to_b),
      .wr_addr  (req_elem_index[AW-1:0]),
      .wr_data  (req_elem_value[DATA_WIDTH-1:0]),
      .addr_a   (addr_a),
      .addr_b   (addr_b),
      .term_in  (term_s0),
      .term_out (term_s1),
      .opa      (opa),
      .opb      (opb)
   );

   mmt_mac #(.DATA_WIDTH(DATA_WIDTH), .MAX_DIM(MAX_DIM)) u_mac (
      .clock          (clock),
      .reset          (reset),
      .term_in        (term_s1),
      .opa            (opa),
      .opb            (opb),
      .rsp_valid      (rsp_valid),
      .rsp_prod_value (rsp_prod_value),
      .rsp_prod_index (rsp_prod_index),
      .rsp_overflowed (rsp_overflowed),
      .rsp_last_elem  (rsp_last_elem)
   );

endmodule

[rtl/core/mmt_ram.sv]
// Generic RAM: one write port, one read port with registered read data
`timescale 1ns / 1ps
module mmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mmt_store.sv]
// Operand stores A and B with per-entry valid bits (unwritten entries read zero)
`timescale 1ns / 1ps
module mmt_store
   import mmt_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
   localparam int AW = $clog2(MAX_ELEMS),
   localparam int SPAN = (MAX_DIM * MAX_DIM > MAX_ELEMS) ? MAX_DIM * MAX_DIM : MAX_ELEMS,
   localparam int IW = $clog2(SPAN)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic                         wr_to_b,
   input  logic [AW-1:0]                wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [IW-1:0]                addr_a,
   input  logic [IW-1:0]                addr_b,
   input  term_ctrl_type                term_in,
   output term_ctrl_type                term_out,
   output logic signed [DATA_WIDTH-1:0] opa,
   output logic signed [DATA_WIDTH-1:0] opb
);

   logic [MAX_ELEMS-1:0]  va_ff, va_in;
   logic [MAX_ELEMS-1:0]  vb_ff, vb_in;
   logic                  live_a_ff, live_a_in;
   logic                  live_b_ff, live_b_in;
   term_ctrl_type         term_ff;
   logic [DATA_WIDTH-1:0] rd_a, rd_b;
   logic                  ok_a, ok_b;

   // storage
   mmt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en && !wr_to_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_a[AW-1:0]),
      .rd_data (rd_a)
   );

   mmt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en && wr_to_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_b[AW-1:0]),
      .rd_data (rd_b)
   );

   // operand addresses past the store read as zero
   assign ok_a = ({1'b0, addr_a} < (IW+1)'(MAX_ELEMS));
   assign ok_b = ({1'b0, addr_b} < (IW+1)'(MAX_ELEMS));

   // valid bits and read qualifiers
   always_comb begin
      va_in = va_ff;
      vb_in = vb_ff;
      if (wr_en && !wr_to_b) begin
         va_in[wr_addr] = 1'b1;
      end
      if (wr_en && wr_to_b) begin
         vb_in[wr_addr] = 1'b1;
      end
      live_a_in = ok_a && va_ff[addr_a[AW-1:0]];
      live_b_in = ok_b && vb_ff[addr_b[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= '0;
         vb_ff     <= '0;
         live_a_ff <= 1'b0;
         live_b_ff <= 1'b0;
         term_ff   <= '0;
      end else begin
         va_ff     <= va_in;
         vb_ff     <= vb_in;
         live_a_ff <= live_a_in;
         live_b_ff <= live_b_in;
         term_ff   <= term_in;
      end
   end

   assign opa      = live_a_ff ? signed'(rd_a) : '0;
   assign opb      = live_b_ff ? signed'(rd_b) : '0;
   assign term_out = term_ff;

endmodule

[rtl/core/mmt_seq.sv]
// Sequencer: walks column, row and term counters and generates operand addresses
`timescale 1ns / 1ps
module mmt_seq
   import mmt_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_ELEMS = MAX_ELEMS_DEF,
   localparam int DIMW = $clog2(MAX_DIM + 1),
   localparam int SPAN = (MAX_DIM * MAX_DIM > MAX_ELEMS) ? MAX_DIM * MAX_DIM : MAX_ELEMS,
   localparam int IW = $clog2(SPAN)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_go,
   input  logic            done_i,
   input  logic [1:0]      layout,
   input  logic [DIMW-1:0] dim_k,
   input  logic [DIMW-1:0] dim_r,
   input  logic [DIMW-1:0] dim_c,
   output logic            busy,
   output term_ctrl_type   term,
   output logic [IW-1:0]   addr_a,
   output logic [IW-1:0]   addr_b
);

   localparam int CW = $clog2(MAX_DIM);

   seq_state_type      state_ff, state_in;
   logic [CW-1:0]      x_ff, x_in;
   logic [CW-1:0]      y_ff, y_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [INDEX_W-1:0] oidx_ff, oidx_in;
   logic               i_end, y_end, x_end;
   logic [IW-1:0]      xw, yw, iw, kw, rw, cw;

   assign i_end = (DIMW'(i_ff) + DIMW'(1) == dim_k);
   assign y_end = (DIMW'(y_ff) + DIMW'(1) == dim_r);
   assign x_end = (DIMW'(x_ff) + DIMW'(1) == dim_c);

   // address generation
   always_comb begin
      xw = IW'(x_ff);
      yw = IW'(y_ff);
      iw = IW'(i_ff);
      kw = IW'(dim_k);
      rw = IW'(dim_r);
      cw = IW'(dim_c);
      case (layout)
         LAYOUT_A_T: begin
            addr_a = yw * kw + iw;
            addr_b = xw * kw + iw;
         end
         LAYOUT_B_T: begin
            addr_a = iw * rw + yw;
            addr_b = iw * cw + xw;
         end
         default: begin
            addr_a = iw * rw + yw;
            addr_b = xw * kw + iw;
         end
      endcase
   end

   // next state and term issue
   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      i_in       = i_ff;
      oidx_in    = oidx_ff;
      term.valid = 1'b0;
      term.first = (i_ff == '0);
      term.fin   = i_end;
      term.last  = x_end && y_end;
      term.idx   = oidx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_go) begin
               state_in = ST_RUN;
               x_in     = '0;
               y_in     = '0;
               i_in     = '0;
               oidx_in  = '0;
            end
         end
         ST_RUN: begin
            term.valid = 1'b1;
            if (i_end) begin
               i_in    = '0;
               oidx_in = oidx_ff + INDEX_W'(1);
               if (y_end) begin
                  y_in = '0;
                  if (x_end) begin
                     state_in = ST_DRAIN;
                  end else begin
                     x_in = x_ff + CW'(1);
                  end
               end else begin
                  y_in = y_ff + CW'(1);
               end
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (done_i) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= '0;
         y_ff     <= '0;
         i_ff     <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         i_ff     <= i_in;
         oidx_ff  <= oidx_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`include "matrix_multiply_transposable_core_assert.svh"

   `MMT_ASSERT_IMPLIES(a_idle_no_issue, clock, reset, state_ff == ST_IDLE, !term.valid)
   `MMT_ASSERT_NEXT(a_go_busy, clock, reset, cmd_go && !busy, busy)
   `MMT_ASSERT_IMPLIES(a_last_is_fin, clock, reset, term.valid && term.last && term.fin,
                       state_in == ST_DRAIN)

endmodule

[rtl/core/mmt_mac.sv]
// Shared multiply-accumulate unit with fraction shift, saturation and result register
`timescale 1ns / 1ps
module mmt_mac
   import mmt_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  term_ctrl_type                term_in,
   input  logic signed [DATA_WIDTH-1:0] opa,
   input  logic signed [DATA_WIDTH-1:0] opb,
   output logic                         rsp_valid,
   output logic signed [VALUE_W-1:0]    rsp_prod_value,
   output logic [INDEX_W-1:0]           rsp_prod_index,
   output logic                         rsp_overflowed,
   output logic                         rsp_last_elem
);

   localparam int PW   = 2 * DATA_WIDTH;
   localparam int ACCW = PW + $clog2(MAX_DIM) + 1;
   localparam int FRAC = DATA_WIDTH / 2;
   localparam int SHW  = ACCW - FRAC;
   localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   term_ctrl_type                term2_ff, term3_ff;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [ACCW-1:0]       acc_ff, acc_in;
   logic signed [SHW-1:0]        shifted;
   logic [SHW-DATA_WIDTH:0]      top_bits;
   logic                         ovf;
   logic signed [DATA_WIDTH-1:0] sat_val;
   logic                         rsp_valid_ff;
   logic signed [VALUE_W-1:0]    value_ff;
   logic [INDEX_W-1:0]           index_ff;
   logic                         ovf_ff, last_ff;

   // multiply stage
   assign prod_in = PW'(opa) * PW'(opb);

   // accumulate stage: restart on the first term of each element
   always_comb begin
      acc_in = acc_ff;
      if (term2_ff.valid) begin
         acc_in = term2_ff.first ? ACCW'(prod_ff) : acc_ff + ACCW'(prod_ff);
      end
   end

   // floor shift by the fraction bits, then clamp to the data range
   always_comb begin
      shifted  = acc_ff[ACCW-1:FRAC];
      top_bits = shifted[SHW-1:DATA_WIDTH-1];
      ovf      = !((&top_bits) || !(|top_bits));
      if (ovf) begin
         sat_val = shifted[SHW-1] ? MINV : MAXV;
      end else begin
         sat_val = shifted[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term2_ff     <= '0;
         term3_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         term2_ff     <= term_in;
         term3_ff     <= term2_ff;
         rsp_valid_ff <= term3_ff.valid && term3_ff.fin;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (term3_ff.valid && term3_ff.fin) begin
         value_ff <= VALUE_W'(sat_val);
         index_ff <= term3_ff.idx;
         ovf_ff   <= ovf;
         last_ff  <= term3_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prod_value = value_ff;
   assign rsp_prod_index = index_ff;
   assign rsp_overflowed = ovf_ff;
   assign rsp_last_elem  = last_ff;

`include "matrix_multiply_transposable_core_assert.svh"

   `MMT_ASSERT_NEXT(a_fin_gives_word, clock, reset, term3_ff.valid && term3_ff.fin, rsp_valid)
   `MMT_ASSERT_IMPLIES(a_ovf_on_rail, clock, reset, rsp_valid && rsp_overflowed,
                       rsp_prod_value == VALUE_W'(MAXV) || rsp_prod_value == VALUE_W'(MINV))
   `MMT_ASSERT_IMPLIES(a_restart_at_boundary, clock, reset,
                       term2_ff.valid && !term2_ff.first,
                       $past(term2_ff.valid) && !$past(term2_ff.fin))

endmodule
